// ===== rtl/core/heading_rotated_dead_reckoning_assert.svh =====
// Assertion macros for the heading-rotated dead reckoning block.
`ifndef HEADING_ROTATED_DEAD_RECKONING_ASSERT_SVH
`define HEADING_ROTATED_DEAD_RECKONING_ASSERT_SVH

// Same-cycle implication, checked on the block clock outside reset.
`define HRDR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrdr: same-cycle check failed");

// Next-cycle implication, checked on the block clock outside reset.
`define HRDR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrdr: next-cycle check failed");

`endif

// ===== rtl/core/hrdr_pkg.sv =====
// Shared types, constants and the CORDIC angle table for the dead reckoning block.
`default_nettype none

package hrdr_pkg;

  localparam int BODY_W    = 16;
  localparam int HEADING_W = 16;
  localparam int POS_OUT_W = 48;

  // Heading resolution per turn; finer bits of the heading are dropped.
  localparam int ANGLE_BITS = 16;
  localparam int HEAD_DROP  = (ANGLE_BITS < HEADING_W) ? (HEADING_W - ANGLE_BITS) : 0;
  localparam logic [HEADING_W-1:0] HEAD_MASK =
    ~HEADING_W'((32'd1 << HEAD_DROP) - 32'd1);

  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_IW    = 5;
  localparam int ANGLE_TW     = 30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORD,
    ST_MUL,
    ST_VEL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_POS,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // atan(2^-i) in Q0.30 quarter turns, scaled so that 2^30 is a quarter turn.
  function automatic logic [ANGLE_TW-1:0] cordic_angle(input logic [CORDIC_IW-1:0] i);
    logic [ANGLE_TW-1:0] a;
    case (i)
      5'd0:    a = 30'd536870912;
      5'd1:    a = 30'd316933406;
      5'd2:    a = 30'd167458907;
      5'd3:    a = 30'd85004756;
      5'd4:    a = 30'd42667331;
      5'd5:    a = 30'd21354465;
      5'd6:    a = 30'd10679838;
      5'd7:    a = 30'd5340245;
      5'd8:    a = 30'd2670163;
      5'd9:    a = 30'd1335087;
      5'd10:   a = 30'd667544;
      5'd11:   a = 30'd333772;
      5'd12:   a = 30'd166886;
      5'd13:   a = 30'd83443;
      5'd14:   a = 30'd41722;
      5'd15:   a = 30'd20861;
      5'd16:   a = 30'd10430;
      5'd17:   a = 30'd5215;
      5'd18:   a = 30'd2608;
      5'd19:   a = 30'd1304;
      5'd20:   a = 30'd652;
      5'd21:   a = 30'd326;
      5'd22:   a = 30'd163;
      5'd23:   a = 30'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hrdr_in_if.sv =====
// Input channel interface: update items with action, body velocity increments and heading.
`default_nettype none

interface hrdr_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    action;
  logic signed [hrdr_pkg::BODY_W-1:0]      body_vel_x;
  logic signed [hrdr_pkg::BODY_W-1:0]      body_vel_y;
  logic signed [hrdr_pkg::HEADING_W-1:0]   heading;

  modport source (output valid, action, body_vel_x, body_vel_y, heading, input ready);
  modport sink   (input valid, action, body_vel_x, body_vel_y, heading, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hrdr_out_if.sv =====
// Result channel interface: north and east position items.
`default_nettype none

interface hrdr_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [hrdr_pkg::POS_OUT_W-1:0]   north_pos;
  logic signed [hrdr_pkg::POS_OUT_W-1:0]   east_pos;

  modport source (output valid, north_pos, east_pos, input ready);
  modport sink   (input valid, north_pos, east_pos, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hrdr_cordic.sv =====
// Iterative CORDIC unit producing Q1.15 sine and cosine of a binary-angle heading.
`default_nettype none

module hrdr_cordic (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [hrdr_pkg::HEADING_W-1:0]         heading,
  output hrdr_pkg::unit_sts_t                    sts,
  output logic signed [15:0]                     sin_q,
  output logic signed [15:0]                     cos_q
);

  localparam logic signed [32:0] X_INIT    = 33'sd652032874;
  localparam logic signed [32:0] QUARTER   = 33'sd1073741824;
  localparam logic signed [32:0] HALF_TURN = 33'sd2147483648;
  localparam logic [hrdr_pkg::CORDIC_IW-1:0] LAST_STEP =
    hrdr_pkg::CORDIC_IW'(hrdr_pkg::CORDIC_STEPS - 1);

  logic signed [32:0] x_r, y_r, z_r;
  logic [hrdr_pkg::CORDIC_IW-1:0] iter_r;
  logic flip_r, run_r, fin_r, done_r;
  logic signed [15:0] sin_r, cos_r;

  logic [hrdr_pkg::HEADING_W-1:0] head_q;
  logic signed [32:0] z_start, z_fold, x_shift, y_shift, ang;
  logic fold;

  function automatic logic signed [15:0] to_q15(input logic signed [32:0] v);
    logic signed [33:0] t;
    logic signed [18:0] r;
    t = 34'(v) + 34'sd16384;
    r = 19'(t >>> 15);
    if (r > 19'sd32767) begin
      return 16'sh7fff;
    end else if (r < -19'sd32768) begin
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

  always_comb begin
    head_q  = heading & hrdr_pkg::HEAD_MASK;
    z_start = 33'(signed'({head_q, 16'h0000}));
    // Angles beyond a quarter turn are folded by half a turn and the result negated.
    fold    = (z_start > QUARTER) || (z_start < -QUARTER);
    if (!fold) begin
      z_fold = z_start;
    end else if (z_start > 33'sd0) begin
      z_fold = z_start - HALF_TURN;
    end else begin
      z_fold = z_start + HALF_TURN;
    end
    x_shift = x_r >>> iter_r;
    y_shift = y_r >>> iter_r;
    ang     = signed'({3'b000, hrdr_pkg::cordic_angle(iter_r)});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r    <= X_INIT;
        y_r    <= '0;
        z_r    <= z_fold;
        flip_r <= fold;
        iter_r <= '0;
        run_r  <= 1'b1;
        fin_r  <= 1'b0;
      end else if (run_r) begin
        if (!z_r[32]) begin
          x_r <= x_r - y_shift;
          y_r <= y_r + x_shift;
          z_r <= z_r - ang;
        end else begin
          x_r <= x_r + y_shift;
          y_r <= y_r - x_shift;
          z_r <= z_r + ang;
        end
        iter_r <= iter_r + 1'b1;
        if (iter_r == LAST_STEP) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        cos_r  <= to_q15(flip_r ? -x_r : x_r);
        sin_r  <= to_q15(flip_r ? -y_r : y_r);
      end
    end
  end

  assign sts.busy = run_r || fin_r;
  assign sts.done = done_r;
  assign sin_q    = sin_r;
  assign cos_q    = cos_r;

endmodule

`default_nettype wire

// ===== rtl/core/hrdr_div25.sv =====
// Radix-8 digit-serial floor division of a signed value by 25.
`default_nettype none

module hrdr_div25 #(
  parameter int NUM_W = 54
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [NUM_W-1:0]  num,
  output hrdr_pkg::unit_sts_t      sts,
  output logic signed [NUM_W-1:0]  quo
);

  localparam int N_DIG = (NUM_W + 2) / 3;
  localparam int PAD_W = 3 * N_DIG;
  localparam int CNT_W = $clog2(N_DIG);
  localparam logic [CNT_W-1:0] LAST_DIG = CNT_W'(N_DIG - 1);

  logic [PAD_W-1:0] mag_r, quo_r;
  logic [4:0]       rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r, run_r, fin_r, done_r;
  logic signed [NUM_W-1:0] res_r;

  logic [NUM_W-1:0] num_abs, q_adj;
  logic [7:0]       part;
  logic [2:0]       qd;
  logic [7:0]       part_rem;

  // Quotient digit of a partial remainder below 200.
  function automatic logic [2:0] digit25(input logic [7:0] p);
    logic [2:0] d;
    if (p >= 8'd175)      d = 3'd7;
    else if (p >= 8'd150) d = 3'd6;
    else if (p >= 8'd125) d = 3'd5;
    else if (p >= 8'd100) d = 3'd4;
    else if (p >= 8'd75)  d = 3'd3;
    else if (p >= 8'd50)  d = 3'd2;
    else if (p >= 8'd25)  d = 3'd1;
    else                  d = 3'd0;
    return d;
  endfunction

  always_comb begin
    num_abs  = num[NUM_W-1] ? (~num + 1'b1) : num;
    part     = {rem_r, mag_r[PAD_W-1 -: 3]};
    qd       = digit25(part);
    part_rem = part - (8'(qd) * 8'd25);
    // Negative dividends round the magnitude quotient away from zero for floor.
    q_adj    = quo_r[NUM_W-1:0] + NUM_W'(neg_r && (rem_r != 5'd0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        mag_r <= PAD_W'(num_abs);
        quo_r <= '0;
        rem_r <= '0;
        neg_r <= num[NUM_W-1];
        cnt_r <= '0;
        run_r <= 1'b1;
        fin_r <= 1'b0;
      end else if (run_r) begin
        mag_r <= mag_r << 3;
        quo_r <= {quo_r[PAD_W-4:0], qd};
        rem_r <= part_rem[4:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_DIG) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        res_r  <= neg_r ? signed'(-q_adj) : signed'(q_adj);
      end
    end
  end

  assign sts.busy = run_r || fin_r;
  assign sts.done = done_r;
  assign quo      = res_r;

endmodule

`default_nettype wire

// ===== rtl/core/heading_rotated_dead_reckoning.sv =====
// Top level: sequencer, shared multiplier and saturating accumulators for dead reckoning.
//
//   Channel | Role   | Handshake     | Payload
//   --------+--------+---------------+-----------------------------------------------
//   in_ch   | sink   | valid / ready | action, body_vel_x, body_vel_y, heading
//   out_ch  | source | valid / ready | north_pos, east_pos (Q32.16, saturating)
//
// An integrate item runs the CORDIC loop, then the shared 16x16 multiplier, then two
// passes of the radix-8 divide-by-25 unit, one per axis. A clear item goes from idle
// straight to the output state.
// One item is in flight at a time; ready is high only while the sequencer is idle.
// The result register lets a new item be taken while the previous result waits.
// Reset is synchronous and clears velocities, positions and all control state.
`default_nettype none

`include "heading_rotated_dead_reckoning_assert.svh"

module heading_rotated_dead_reckoning #(
  parameter int VELOCITY_WIDTH = 48,
  parameter int POSITION_WIDTH = 56
) (
  input  logic        clk,
  input  logic        rst_n,
  hrdr_in_if.sink     in_ch,
  hrdr_out_if.source  out_ch
);

  localparam int VW   = VELOCITY_WIDTH;
  localparam int PW   = POSITION_WIDTH;
  localparam int OW   = hrdr_pkg::POS_OUT_W;
  localparam int DW   = 33;
  localparam int VUW  = VW + 4;
  localparam int NW   = VW + 6;
  localparam int IW   = (NW > 64) ? 64 : NW;
  localparam int SW   = ((NW > PW) ? NW : PW) + 1;
  localparam int RW   = ((PW > OW) ? PW : OW) + 1;

  localparam logic signed [VUW-1:0] VMAX = signed'({{(VUW-VW+1){1'b0}}, {(VW-1){1'b1}}});
  localparam logic signed [VUW-1:0] VMIN = ~VMAX;
  localparam logic signed [SW-1:0]  IMAX = signed'({{(SW-IW+1){1'b0}}, {(IW-1){1'b1}}});
  localparam logic signed [SW-1:0]  IMIN = ~IMAX;
  localparam logic signed [SW-1:0]  PMAX = signed'({{(SW-PW+1){1'b0}}, {(PW-1){1'b1}}});
  localparam logic signed [SW-1:0]  PMIN = ~PMAX;
  localparam logic signed [RW-1:0]  OMAX = signed'({{(RW-OW+1){1'b0}}, {(OW-1){1'b1}}});
  localparam logic signed [RW-1:0]  OMIN = ~OMAX;
  localparam logic [2:0] MUL_LAST = 3'd4;

  hrdr_pkg::state_t state_r, state_nxt;

  logic signed [15:0]  bx_r, by_r;
  logic [2:0]          mcnt_r;
  logic signed [31:0]  prod_r;
  logic signed [DW-1:0] dn_r, de_r;
  logic signed [VW-1:0] vel_n_r, vel_e_r, vold_n_r, vold_e_r;
  logic signed [PW-1:0] pos_n_r, pos_e_r;
  logic                 axis_r;
  logic                 out_valid_r;
  logic signed [OW-1:0] out_n_r, out_e_r;

  logic in_acc, cordic_start, div_start, out_load;
  hrdr_pkg::unit_sts_t cordic_sts, div_sts;
  logic signed [15:0]  sin_q, cos_q;
  logic signed [15:0]  mul_a, mul_b;
  logic signed [31:0]  prod_w;
  logic signed [VUW-1:0] vsum_n, vsum_e, vcl_n, vcl_e;
  logic signed [VW:0]    vpair;
  logic signed [NW-1:0]  div_num, div_quo;
  logic signed [SW-1:0]  inc_ext, inc_cl, psum, pcl;
  logic signed [PW-1:0]  pos_sel;
  logic signed [RW-1:0]  rnd_n, rnd_e, ocl_n, ocl_e;

  hrdr_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cordic_start),
    .heading (in_ch.heading),
    .sts     (cordic_sts),
    .sin_q   (sin_q),
    .cos_q   (cos_q)
  );

  hrdr_div25 #(
    .NUM_W (NW)
  ) u_div25 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .sts   (div_sts),
    .quo   (div_quo)
  );

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    in_ch.ready  = 1'b0;
    cordic_start = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    in_acc       = 1'b0;
    case (state_r)
      hrdr_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        in_acc      = in_ch.valid;
        if (in_ch.valid) begin
          if (in_ch.action) begin
            state_nxt = hrdr_pkg::ST_OUT;
          end else begin
            cordic_start = 1'b1;
            state_nxt    = hrdr_pkg::ST_CORD;
          end
        end
      end
      hrdr_pkg::ST_CORD: begin
        if (cordic_sts.done) state_nxt = hrdr_pkg::ST_MUL;
      end
      hrdr_pkg::ST_MUL: begin
        if (mcnt_r == MUL_LAST) state_nxt = hrdr_pkg::ST_VEL;
      end
      hrdr_pkg::ST_VEL: begin
        state_nxt = hrdr_pkg::ST_DIV_GO;
      end
      hrdr_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = hrdr_pkg::ST_DIV_WAIT;
      end
      hrdr_pkg::ST_DIV_WAIT: begin
        if (div_sts.done) state_nxt = hrdr_pkg::ST_POS;
      end
      hrdr_pkg::ST_POS: begin
        state_nxt = axis_r ? hrdr_pkg::ST_OUT : hrdr_pkg::ST_DIV_GO;
      end
      hrdr_pkg::ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = hrdr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hrdr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hrdr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath arithmetic.
  always_comb begin
    case (mcnt_r)
      3'd0:    begin mul_a = bx_r; mul_b = cos_q; end
      3'd1:    begin mul_a = by_r; mul_b = sin_q; end
      3'd2:    begin mul_a = bx_r; mul_b = sin_q; end
      default: begin mul_a = by_r; mul_b = cos_q; end
    endcase
    prod_w = mul_a * mul_b;

    vsum_n = VUW'(vel_n_r) + (VUW'(dn_r) <<< 1);
    vsum_e = VUW'(vel_e_r) + (VUW'(de_r) <<< 1);
    vcl_n  = (vsum_n > VMAX) ? VMAX : ((vsum_n < VMIN) ? VMIN : vsum_n);
    vcl_e  = (vsum_e > VMAX) ? VMAX : ((vsum_e < VMIN) ? VMIN : vsum_e);

    // Position step is round(16 * (v_new + v_old) / 25) in Q.24; the bias of 12 rounds.
    vpair   = axis_r ? ((VW+1)'(vel_e_r) + (VW+1)'(vold_e_r))
                     : ((VW+1)'(vel_n_r) + (VW+1)'(vold_n_r));
    div_num = (NW'(vpair) <<< 4) + NW'(12);

    pos_sel = axis_r ? pos_e_r : pos_n_r;
    inc_ext = SW'(div_quo);
    inc_cl  = (inc_ext > IMAX) ? IMAX : ((inc_ext < IMIN) ? IMIN : inc_ext);
    psum    = SW'(pos_sel) + inc_cl;
    pcl     = (psum > PMAX) ? PMAX : ((psum < PMIN) ? PMIN : psum);

    // Q.24 to Q.16 with the half bit added back in.
    rnd_n = RW'(pos_n_r >>> 8) + RW'(signed'({1'b0, pos_n_r[7]}));
    rnd_e = RW'(pos_e_r >>> 8) + RW'(signed'({1'b0, pos_e_r[7]}));
    ocl_n = (rnd_n > OMAX) ? OMAX : ((rnd_n < OMIN) ? OMIN : rnd_n);
    ocl_e = (rnd_e > OMAX) ? OMAX : ((rnd_e < OMIN) ? OMIN : rnd_e);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_n_r     <= '0;
      vel_e_r     <= '0;
      pos_n_r     <= '0;
      pos_e_r     <= '0;
      mcnt_r      <= '0;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_n_r     <= ocl_n[OW-1:0];
        out_e_r     <= ocl_e[OW-1:0];
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        hrdr_pkg::ST_IDLE: begin
          if (in_acc) begin
            bx_r   <= in_ch.body_vel_x;
            by_r   <= in_ch.body_vel_y;
            mcnt_r <= '0;
            axis_r <= 1'b0;
            if (in_ch.action) begin
              vel_n_r <= '0;
              vel_e_r <= '0;
              pos_n_r <= '0;
              pos_e_r <= '0;
            end
          end
        end
        hrdr_pkg::ST_MUL: begin
          // The product of each step is summed in the cycle after it is registered.
          prod_r <= prod_w;
          mcnt_r <= mcnt_r + 1'b1;
          case (mcnt_r)
            3'd1:    dn_r <= DW'(prod_r);
            3'd2:    dn_r <= dn_r - DW'(prod_r);
            3'd3:    de_r <= DW'(prod_r);
            3'd4:    de_r <= de_r + DW'(prod_r);
            default: ;
          endcase
        end
        hrdr_pkg::ST_VEL: begin
          vold_n_r <= vel_n_r;
          vold_e_r <= vel_e_r;
          vel_n_r  <= vcl_n[VW-1:0];
          vel_e_r  <= vcl_e[VW-1:0];
        end
        hrdr_pkg::ST_POS: begin
          if (axis_r) begin
            pos_e_r <= pcl[PW-1:0];
          end else begin
            pos_n_r <= pcl[PW-1:0];
          end
          axis_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.north_pos = out_n_r;
  assign out_ch.east_pos  = out_e_r;

  `HRDR_ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  `HRDR_ASSERT_NXT(a_clear_zeroes_pos, in_ch.valid && in_ch.ready && in_ch.action, (pos_n_r == '0) && (pos_e_r == '0))
  `HRDR_ASSERT_IMP(a_cordic_in_step, cordic_sts.busy || cordic_sts.done, state_r == hrdr_pkg::ST_CORD)
  `HRDR_ASSERT_IMP(a_div_in_step, div_sts.busy || div_sts.done, state_r == hrdr_pkg::ST_DIV_WAIT)

endmodule

`default_nettype wire

// ===== bench/tb_heading_rotated_dead_reckoning.sv =====
// Self-checking testbench for the heading-rotated dead reckoning block.
`default_nettype none

module tb_heading_rotated_dead_reckoning;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BODY_W     = hrdr_pkg::BODY_W;
  localparam int HEADING_W  = hrdr_pkg::HEADING_W;
  localparam int POS_OUT_W  = hrdr_pkg::POS_OUT_W;
  localparam int ANGLE_BITS = hrdr_pkg::ANGLE_BITS;

  localparam int VEL_W = 48;
  localparam int POS_W = 56;

  localparam logic ACT_INTEGRATE = 1'b0;
  localparam logic ACT_CLEAR     = 1'b1;

  localparam longint CYCLE_LIMIT    = 3_000_000;
  localparam int     RANDOM_ITEMS   = 1200;
  localparam int     OVERFLOW_ITEMS = 400;
  localparam int     HOLD_CYCLES    = 400;
  localparam int     DRAIN_CYCLES   = 100;

  localparam longint QUARTER_TURN = 64'sd1073741824;
  localparam longint HALF_TURN    = 64'sd2147483648;
  localparam longint CORDIC_X0    = 64'sd652032874;
  localparam longint ATAN_Q30 [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct packed {
    logic signed [POS_OUT_W-1:0] north;
    logic signed [POS_OUT_W-1:0] east;
  } pos_fix_t;

  class position_tracker;
    longint      vel_n, vel_e, pos_n, pos_e;
    pos_fix_t    pending[$];
    int unsigned faults;

    function new();
      clear_state();
      faults = 0;
    endfunction

    function void clear_state();
      vel_n = 0;
      vel_e = 0;
      pos_n = 0;
      pos_e = 0;
    endfunction

    static function longint sat_sum(longint a, longint b);
      longint top, bot;
      top = 64'sh7FFF_FFFF_FFFF_FFFF;
      bot = -top - 1;
      if (b > 0 && a > top - b) return top;
      if (b < 0 && a < bot - b) return bot;
      return a + b;
    endfunction

    static function longint clamp_to(longint v, int w);
      longint hi, lo;
      if (w >= 64) return v;
      hi = (longint'(1) << (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    static function longint round_q15(longint v);
      longint r;
      r = (v + 16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r;
    endfunction

    // Rotation-mode CORDIC in Q2.30; angles beyond a quarter turn are folded
    // back by half a turn and the vector negated afterwards.
    static function void heading_sin_cos(logic [HEADING_W-1:0] hd,
                                         output longint s, output longint c);
      logic [31:0] phase;
      longint      x, y, z, t;
      bit          flip;
      phase = {hd, 16'h0000};
      phase &= ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
      z = longint'($signed(phase));
      x = CORDIC_X0;
      y = 0;
      flip = 1'b0;
      if (z > QUARTER_TURN || z < -QUARTER_TURN) begin
        flip = 1'b1;
        z = (z > 0) ? z - HALF_TURN : z + HALF_TURN;
      end
      for (int i = 0; i < 24; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z -= ATAN_Q30[i];
        end else begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z += ATAN_Q30[i];
        end
        x = t;
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      c = round_q15(x);
      s = round_q15(y);
    endfunction

    static function void floor_div25(longint v, output longint q, output longint r);
      q = v / 25;
      r = v % 25;
      if (r < 0) begin
        r += 25;
        q -= 1;
      end
    endfunction

    // (v_new + v_old) * 16/25 in Q.24, split per operand to stay exact.
    static function longint trapezoid_step(longint v_new, longint v_old);
      longint qa, ra, qb, rb, inc;
      floor_div25(v_new, qa, ra);
      floor_div25(v_old, qb, rb);
      inc = sat_sum(qa * 16, qb * 16);
      return sat_sum(inc, (16 * (ra + rb) + 12) / 25);
    endfunction

    static function logic signed [POS_OUT_W-1:0] q16_pos(longint acc);
      longint r;
      r = (acc >>> 8) + ((acc >> 7) & 64'sd1);
      r = clamp_to(r, POS_OUT_W);
      return r[POS_OUT_W-1:0];
    endfunction

    function void absorb_update(logic act, logic signed [BODY_W-1:0] bx,
                                logic signed [BODY_W-1:0] by, logic [HEADING_W-1:0] hd);
      longint s, c, dn, de, old_n, old_e;
      pos_fix_t fix;
      if (act == ACT_CLEAR) begin
        clear_state();
      end else begin
        heading_sin_cos(hd, s, c);
        dn = (longint'(bx) * c - longint'(by) * s) * 2;
        de = (longint'(bx) * s + longint'(by) * c) * 2;
        old_n = vel_n;
        old_e = vel_e;
        vel_n = clamp_to(sat_sum(vel_n, dn), VEL_W);
        vel_e = clamp_to(sat_sum(vel_e, de), VEL_W);
        pos_n = clamp_to(sat_sum(pos_n, trapezoid_step(vel_n, old_n)), POS_W);
        pos_e = clamp_to(sat_sum(pos_e, trapezoid_step(vel_e, old_e)), POS_W);
      end
      fix.north = q16_pos(pos_n);
      fix.east  = q16_pos(pos_e);
      pending.push_back(fix);
    endfunction

    function void compare_fix(logic signed [POS_OUT_W-1:0] north,
                              logic signed [POS_OUT_W-1:0] east);
      pos_fix_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result item: north %0d, east %0d", $time, north, east);
        faults++;
        return;
      end
      want = pending.pop_front();
      if (north !== want.north) begin
        $display("%0t: north_pos mismatch: expected %0d, actual %0d",
                 $time, want.north, north);
        faults++;
      end
      if (east !== want.east) begin
        $display("%0t: east_pos mismatch: expected %0d, actual %0d",
                 $time, want.east, east);
        faults++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   pace_on;

  hrdr_in_if  in_ch();
  hrdr_out_if out_ch();

  position_tracker tracker = new();

  heading_rotated_dead_reckoning #(
    .VELOCITY_WIDTH(VEL_W),
    .POSITION_WIDTH(POS_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    longint cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_heading_rotated_dead_reckoning: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tracker.compare_fix(out_ch.north_pos, out_ch.east_pos);
    end
  end

  // Result side: short random stalls, plus a few long hold-offs so that the
  // block fills up and has to refuse input.
  initial begin
    int          gap;
    int unsigned taken;
    taken = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == 40 || taken == 1200 || taken == 3000) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = pace_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  task automatic send_item(input logic act, input logic signed [BODY_W-1:0] bx,
                           input logic signed [BODY_W-1:0] by,
                           input logic [HEADING_W-1:0] hd);
    int gap;
    gap = pace_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.body_vel_x <= bx;
    in_ch.body_vel_y <= by;
    in_ch.heading    <= hd;
    do @(posedge clk); while (!in_ch.ready);
    tracker.absorb_update(act, bx, by, hd);
  endtask

  task automatic send_random(input int count);
    int pick;
    logic signed [BODY_W-1:0] bx, by;
    logic [HEADING_W-1:0] hd;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) pace_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      hd = HEADING_W'($urandom_range(0, 65535));
      if (pick < 15) begin
        bx = BODY_W'($urandom_range(0, 128)) - BODY_W'(64);
        by = BODY_W'($urandom_range(0, 128)) - BODY_W'(64);
      end else begin
        bx = BODY_W'($urandom_range(0, 65535));
        by = BODY_W'($urandom_range(0, 65535));
      end
      send_item(pick < 5 ? ACT_CLEAR : ACT_INTEGRATE, bx, by, hd);
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_INTEGRATE;
    in_ch.body_vel_x <= '0;
    in_ch.body_vel_y <= '0;
    in_ch.heading    <= '0;
    pace_on = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes, the quadrant boundaries where the angle is folded, and
    // clear items with arbitrary payloads.
    send_item(ACT_INTEGRATE, 16'sd0, 16'sd0, 16'h0000);
    send_item(ACT_INTEGRATE, 16'sd32767, 16'sd0, 16'h0000);
    send_item(ACT_INTEGRATE, -16'sd32768, 16'sd0, 16'h0000);
    send_item(ACT_INTEGRATE, 16'sd0, 16'sd32767, 16'h4000);
    send_item(ACT_INTEGRATE, 16'sd0, -16'sd32768, 16'hC000);
    send_item(ACT_INTEGRATE, 16'sd1, -16'sd1, 16'h4001);
    send_item(ACT_INTEGRATE, -16'sd1, 16'sd1, 16'hBFFF);
    send_item(ACT_INTEGRATE, 16'sd100, 16'sd200, 16'h8000);
    send_item(ACT_INTEGRATE, 16'sd300, -16'sd400, 16'h7FFF);
    send_item(ACT_CLEAR, 16'sh7FFF, 16'sh7FFF, 16'hFFFF);
    send_item(ACT_CLEAR, -16'sd1, -16'sd1, 16'h5555);
    send_item(ACT_INTEGRATE, 16'sd32767, 16'sd32767, 16'h2000);
    send_item(ACT_INTEGRATE, -16'sd32768, -16'sd32768, 16'hE000);
    send_item(ACT_INTEGRATE, 16'sd5, 16'sd7, 16'h0001);
    send_item(ACT_INTEGRATE, -16'sd5, -16'sd7, 16'hFFFF);
    send_item(ACT_INTEGRATE, -16'sd1, 16'sd1, 16'h6000);
    send_item(ACT_INTEGRATE, 16'sd12345, -16'sd23456, 16'hA000);
    send_item(ACT_CLEAR, 16'sd0, 16'sd0, 16'h0000);
    send_item(ACT_INTEGRATE, 16'sh2AAA, 16'shD555, 16'h2AAA);

    send_random(RANDOM_ITEMS);

    // Full thrust north and full thrust west to build up large velocities
    // and positions, then reverse thrust for a few items.
    send_item(ACT_CLEAR, 16'sd0, 16'sd0, 16'h0000);
    for (int i = 0; i < OVERFLOW_ITEMS; i++) begin
      if (i % 500 == 0) pace_on = ($urandom_range(0, 1) != 0);
      send_item(ACT_INTEGRATE, 16'sd32767, -16'sd32768, 16'h0000);
    end
    for (int i = 0; i < 10; i++) begin
      send_item(ACT_INTEGRATE, -16'sd32768, 16'sd32767, 16'h0000);
    end
    send_item(ACT_CLEAR, 16'sd0, 16'sd0, 16'h0000);
    send_random(20);
    in_ch.valid <= 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.faults == 0 && tracker.pending.size() == 0) begin
      $display("tb_heading_rotated_dead_reckoning: PASS");
    end else begin
      $display("tb_heading_rotated_dead_reckoning: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/hrdr_pkg.sv
rtl/core/hrdr_in_if.sv
rtl/core/hrdr_out_if.sv
rtl/core/hrdr_cordic.sv
rtl/core/hrdr_div25.sv
rtl/core/heading_rotated_dead_reckoning.sv
bench/tb_heading_rotated_dead_reckoning.sv
